// ===== sv/rrc_pkg.sv =====
// Shared constants, types and arithmetic helpers of the rotated rectangle collision pipeline.
package rrc_pkg;

	localparam int CW     = 32;        // coordinate width, Q16.16
	localparam int AW     = 16;        // binary angle width
	localparam int TW     = 32;        // sine and cosine word, Q2.30
	localparam int TFRAC  = 30;
	localparam int NSTEP  = 24;        // CORDIC iterations, one pipeline stage each
	localparam int XW     = 40;        // signed width of frame coordinates
	localparam int NW     = 34;        // magnitude width of numerator and divisor
	localparam int MW     = 37;        // magnitude width of the multiplier operand
	localparam int MLO    = 18;        // low slice of the split multiplication
	localparam int PW     = NW + MW;   // product width
	localparam int QB     = 36;        // quotient bits, saturation is 2^QB - 1
	localparam int DIV_LAT = QB + 2;

	localparam logic signed [TW-1:0] CORDIC_START = 32'sd652032874;
	localparam logic signed [TW-1:0] TRIG_ONE     = 32'sd1073741824;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic signed [TW-1:0] ATAN [NSTEP] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81
	};

	typedef struct packed {
		logic signed [TW-1:0] x;
		logic signed [TW-1:0] y;
		logic signed [TW-1:0] z;
	} cor_t;

	typedef struct packed {
		logic [1:0]           quad;
		logic                 zero;
		logic signed [TW-1:0] res;
	} ang_t;

	typedef struct packed {
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
	} cs_t;

	// Operands of one saturating quotient, as magnitudes plus the result sign.
	typedef struct packed {
		logic [NW-1:0] n;
		logic [MW-1:0] m;
		logic [NW-1:0] d;
		logic          neg;
	} div_in_t;

	function automatic ang_t ang_split(input logic [AW-1:0] ang);
		logic [TW-1:0] sh;
		ang_t o;
		sh = {ang, {(TW-AW){1'b0}}} + (TW'(1) << (TFRAC-1));
		o.quad = sh[TW-1:TW-2];
		o.zero = (sh[TFRAC-1:0] == (TFRAC'(1) << (TFRAC-1)));
		o.res = TW'({2'b00, sh[TFRAC-1:0]}) - (TW'(1) << (TFRAC-1));
		return o;
	endfunction

	function automatic cor_t cordic_step(input cor_t c, input int i);
		logic signed [TW-1:0] xs;
		logic signed [TW-1:0] ys;
		cor_t o;
		xs = c.x >>> i;
		ys = c.y >>> i;
		if (c.z >= 0) begin
			o.x = c.x - ys;
			o.y = c.y + xs;
			o.z = c.z - ATAN[i];
		end else begin
			o.x = c.x + ys;
			o.y = c.y - xs;
			o.z = c.z + ATAN[i];
		end
		return o;
	endfunction

	// Quarter-turn rotation of the residual result; an exact quadrant angle is exact.
	function automatic cs_t trig_out(input cor_t c, input ang_t a);
		logic signed [TW-1:0] x;
		logic signed [TW-1:0] y;
		cs_t o;
		x = a.zero ? TRIG_ONE : c.x;
		y = a.zero ? '0 : c.y;
		case (a.quad)
			QUAD_0: begin o.c = x;  o.s = y;  end
			QUAD_1: begin o.c = -y; o.s = x;  end
			QUAD_2: begin o.c = -x; o.s = -y; end
			QUAD_3: begin o.c = y;  o.s = -x; end
			default: begin o.c = x; o.s = y; end
		endcase
		return o;
	endfunction

	// Product with a Q2.30 factor, rounded toward minus infinity.
	function automatic logic signed [XW-1:0] mulq(input logic signed [CW:0] v,
			input logic signed [TW-1:0] c);
		logic signed [CW+TW:0] p;
		p = v * c;
		return XW'(p >>> TFRAC);
	endfunction

	function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
		return v[XW-1] ? XW'(-v) : XW'(v);
	endfunction

endpackage

// ===== sv/rrc_div.sv =====
// Pipelined saturating divider: floor(n * m / d) with sign, one quotient bit per stage.
module rrc_div import rrc_pkg::*; (
	input  logic                 clk,
	input  logic                 adv,
	input  div_in_t              din,
	output logic signed [XW-1:0] quo
);

	typedef struct packed {
		logic [PW-1:0] rem;
		logic [NW-1:0] d;
		logic          neg;
		logic          sat;
		logic          zero;
		logic [QB-1:0] q;
	} dstage_t;

	logic [NW+MLO-1:0]    plo_s1;
	logic [PW-MLO-1:0]    phi_s1;
	logic [NW-1:0]        d_s1;
	logic                 neg_s1;
	logic [PW-1:0]        nprod;
	dstage_t              dv_s [0:QB];
	logic [QB-1:0]        qmag;

	// The wide product is split into two partial products that are registered before they are summed.
	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1 <= din.n * din.m[MLO-1:0];
			phi_s1 <= din.n * din.m[MW-1:MLO];
			d_s1   <= din.d;
			neg_s1 <= din.neg;
		end
	end

	assign nprod = PW'(plo_s1) + (PW'(phi_s1) << MLO);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].rem  <= nprod;
			dv_s[0].d    <= d_s1;
			dv_s[0].neg  <= neg_s1;
			dv_s[0].sat  <= (d_s1 == '0) || (nprod >= (PW'(d_s1) << QB));
			dv_s[0].zero <= (nprod == '0);
			dv_s[0].q    <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [PW-1:0] dsh;
		logic          take;
		dstage_t       nxt;
		assign dsh  = PW'(dv_s[k].d) << B;
		assign take = (dv_s[k].rem >= dsh);
		always_comb begin
			nxt      = dv_s[k];
			nxt.rem  = take ? dv_s[k].rem - dsh : dv_s[k].rem;
			nxt.q[B] = take;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		if (dv_s[QB].zero) begin
			qmag = '0;
		end else if (dv_s[QB].sat) begin
			qmag = '1;
		end else begin
			qmag = dv_s[QB].q;
		end
		quo = dv_s[QB].neg ? -$signed(XW'(qmag)) : $signed(XW'(qmag));
	end

endmodule

// ===== sv/rotated_rectangle_collision.sv =====
// Oriented rectangle overlap test pipeline, top level.
// The block accepts one rectangle pair per cycle while the result side does not stall, and
// returns its overlap bit through the 24 CORDIC stages that form both sines and cosines
// and the 36-stage bit-per-stage divider that finds the vertical extremes. A stall on the
// result side holds every stage in place, and in_ready drops only while a result waits.
module rotated_rectangle_collision import rrc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] a_center_x,
	input  logic signed [CW-1:0] a_center_y,
	input  logic [CW-2:0]        a_half_width,
	input  logic [CW-2:0]        a_half_height,
	input  logic [AW-1:0]        a_angle,
	input  logic signed [CW-1:0] b_center_x,
	input  logic signed [CW-1:0] b_center_y,
	input  logic [CW-2:0]        b_half_width,
	input  logic [CW-2:0]        b_half_height,
	input  logic [AW-1:0]        b_angle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 overlap
);

	localparam int NST = 30 + DIV_LAT + 1;

	typedef struct packed {
		logic signed [CW:0] dx;
		logic signed [CW:0] dy;
		logic [CW-2:0]      ahw;
		logic [CW-2:0]      ahh;
		logic [CW-2:0]      bhw;
		logic [CW-2:0]      bhh;
		ang_t               angb;
		ang_t               angr;
	} pre_t;

	typedef struct packed {
		logic signed [XW-1:0] mxc;
		logic signed [XW-1:0] mys;
		logic signed [XW-1:0] myc;
		logic signed [XW-1:0] mxs;
		logic signed [XW-1:0] p;
		logic signed [XW-1:0] q;
		logic signed [XW-1:0] r;
		logic signed [XW-1:0] u;
		logic [CW-2:0]        bhw;
		logic [CW-2:0]        bhh;
		logic                 s_neg;
		logic                 s_zero;
		logic                 c_neg;
		logic                 c_zero;
	} mul_t;

	typedef struct packed {
		logic signed [XW-1:0] cx;
		logic signed [XW-1:0] cy;
		logic signed [XW-1:0] pax;
		logic signed [XW-1:0] pbx;
		logic signed [XW-1:0] pay;
		logic signed [XW-1:0] pby;
		logic [CW-2:0]        bhw;
		logic [CW-2:0]        bhh;
		logic                 ts_neg;
		logic                 ts_zero;
		logic                 s_neg;
	} geo_t;

	typedef struct packed {
		logic signed [XW-1:0] blx;
		logic signed [XW-1:0] bly;
		logic signed [XW-1:0] trx;
		logic signed [XW-1:0] tr_y;
		logic signed [XW-1:0] pax;
		logic signed [XW-1:0] pbx;
		logic signed [XW-1:0] pay;
		logic signed [XW-1:0] pby;
		logic                 ts_zero;
	} box_t;

	typedef struct packed {
		logic signed [XW-1:0] n1;
		logic signed [XW-1:0] m1;
		logic signed [XW-1:0] d1;
		logic signed [XW-1:0] n2;
		logic signed [XW-1:0] m2;
		logic signed [XW-1:0] d2;
		logic                 cond1;
		logic                 cond2;
		logic                 reject;
		logic signed [XW-1:0] pay;
		logic signed [XW-1:0] bly;
		logic signed [XW-1:0] tr_y;
	} sel_t;

	typedef struct packed {
		logic                 cond1;
		logic                 cond2;
		logic                 reject;
		logic signed [XW-1:0] pay;
		logic signed [XW-1:0] bly;
		logic signed [XW-1:0] tr_y;
	} side_t;

	logic [NST-1:0]       vld_s;
	logic                 adv;
	logic [AW-1:0]        rel_ang;
	ang_t                 angb;
	ang_t                 angr;
	pre_t                 pre_s  [0:NSTEP];
	cor_t                 corb_s [0:NSTEP];
	cor_t                 corr_s [0:NSTEP];
	cs_t                  tb;
	cs_t                  tr;
	mul_t                 mul_s26;
	geo_t                 geo_s27;
	box_t                 box_s28;
	sel_t                 sel_s29;
	sel_t                 sel_d;
	div_in_t              dv1_s30;
	div_in_t              dv2_s30;
	side_t                side_s [0:DIV_LAT];
	logic signed [XW-1:0] quo1;
	logic signed [XW-1:0] quo2;
	logic signed [XW-1:0] e1;
	logic signed [XW-1:0] e2;
	logic                 ovl_s69;

	// The whole pipeline moves together; it halts only when the final word is not taken.
	assign adv       = !vld_s[NST-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NST-1];
	assign overlap   = ovl_s69;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	assign rel_ang = a_angle - b_angle;
	assign angb    = ang_split(b_angle);
	assign angr    = ang_split(rel_ang);

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s[0].dx   <= (CW+1)'(b_center_x) - (CW+1)'(a_center_x);
			pre_s[0].dy   <= (CW+1)'(b_center_y) - (CW+1)'(a_center_y);
			pre_s[0].ahw  <= a_half_width;
			pre_s[0].ahh  <= a_half_height;
			pre_s[0].bhw  <= b_half_width;
			pre_s[0].bhh  <= b_half_height;
			pre_s[0].angb <= angb;
			pre_s[0].angr <= angr;
			corb_s[0]     <= '{x: CORDIC_START, y: '0, z: angb.res};
			corr_s[0]     <= '{x: CORDIC_START, y: '0, z: angr.res};
		end
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				corb_s[i+1] <= cordic_step(corb_s[i], i);
				corr_s[i+1] <= cordic_step(corr_s[i], i);
				pre_s[i+1]  <= pre_s[i];
			end
		end
	end

	assign tb = trig_out(corb_s[NSTEP], pre_s[NSTEP].angb);
	assign tr = trig_out(corr_s[NSTEP], pre_s[NSTEP].angr);

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s26.mxc    <= mulq(pre_s[NSTEP].dx, tb.c);
			mul_s26.mys    <= mulq(pre_s[NSTEP].dy, tb.s);
			mul_s26.myc    <= mulq(pre_s[NSTEP].dy, tb.c);
			mul_s26.mxs    <= mulq(pre_s[NSTEP].dx, tb.s);
			mul_s26.p      <= mulq($signed({2'b00, pre_s[NSTEP].ahh}), tr.s);
			mul_s26.q      <= mulq($signed({2'b00, pre_s[NSTEP].ahw}), tr.c);
			mul_s26.r      <= mulq($signed({2'b00, pre_s[NSTEP].ahh}), tr.c);
			mul_s26.u      <= mulq($signed({2'b00, pre_s[NSTEP].ahw}), tr.s);
			mul_s26.bhw    <= pre_s[NSTEP].bhw;
			mul_s26.bhh    <= pre_s[NSTEP].bhh;
			mul_s26.s_neg  <= tr.s[TW-1];
			mul_s26.s_zero <= (tr.s == '0);
			mul_s26.c_neg  <= tr.c[TW-1];
			mul_s26.c_zero <= (tr.c == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s27.cx      <= mul_s26.mxc + mul_s26.mys;
			geo_s27.cy      <= mul_s26.myc - mul_s26.mxs;
			geo_s27.pax     <= mul_s26.q - mul_s26.p;
			geo_s27.pbx     <= -mul_s26.p - mul_s26.q;
			geo_s27.pay     <= mul_s26.r + mul_s26.u;
			geo_s27.pby     <= mul_s26.r - mul_s26.u;
			geo_s27.bhw     <= mul_s26.bhw;
			geo_s27.bhh     <= mul_s26.bhh;
			geo_s27.ts_neg  <= !mul_s26.s_zero && !mul_s26.c_zero
				&& (mul_s26.s_neg != mul_s26.c_neg);
			geo_s27.ts_zero <= mul_s26.s_zero || mul_s26.c_zero;
			geo_s27.s_neg   <= mul_s26.s_neg;
		end
	end

	// Corners are swapped when sine and cosine differ in sign, then mirrored for a
	// negative sine, so that the second corner always lies on the far right.
	always_ff @(posedge clk) begin
		if (adv) begin
			box_s28.blx     <= geo_s27.cx - XW'(geo_s27.bhw);
			box_s28.bly     <= geo_s27.cy - XW'(geo_s27.bhh);
			box_s28.trx     <= geo_s27.cx + XW'(geo_s27.bhw);
			box_s28.tr_y    <= geo_s27.cy + XW'(geo_s27.bhh);
			box_s28.pax     <= geo_s27.ts_neg ? geo_s27.pbx : geo_s27.pax;
			box_s28.pay     <= geo_s27.ts_neg ? geo_s27.pby : geo_s27.pay;
			if (geo_s27.ts_neg) begin
				box_s28.pbx <= geo_s27.s_neg ? -geo_s27.pax : geo_s27.pax;
				box_s28.pby <= geo_s27.s_neg ? -geo_s27.pay : geo_s27.pay;
			end else begin
				box_s28.pbx <= geo_s27.s_neg ? -geo_s27.pbx : geo_s27.pbx;
				box_s28.pby <= geo_s27.s_neg ? -geo_s27.pby : geo_s27.pby;
			end
			box_s28.ts_zero <= geo_s27.ts_zero;
		end
	end

	always_comb begin
		logic signed [XW-1:0] x1;
		logic signed [XW-1:0] a1;
		logic signed [XW-1:0] x2;
		logic signed [XW-1:0] a2;
		x1 = box_s28.blx - box_s28.pax;
		a1 = box_s28.trx - box_s28.pax;
		x2 = box_s28.blx + box_s28.pax;
		a2 = box_s28.trx + box_s28.pax;
		sel_d.reject = (box_s28.pbx > box_s28.trx) || (box_s28.pbx > -box_s28.blx);
		sel_d.cond1  = !box_s28.ts_zero && (x1 != '0) && (a1 != '0)
			&& (x1[XW-1] == a1[XW-1]);
		sel_d.cond2  = !box_s28.ts_zero && (x2 != '0) && (a2 != '0)
			&& (x2[XW-1] == a2[XW-1]);
		if (x1 < 0) begin
			sel_d.d1 = box_s28.pax - box_s28.pbx;
			sel_d.n1 = box_s28.pay - box_s28.pby;
			sel_d.m1 = a1;
		end else begin
			sel_d.d1 = box_s28.pax + box_s28.pbx;
			sel_d.n1 = box_s28.pay + box_s28.pby;
			sel_d.m1 = x1;
		end
		if (x2 < 0) begin
			sel_d.d2 = -box_s28.pax - box_s28.pbx;
			sel_d.n2 = -box_s28.pay - box_s28.pby;
			sel_d.m2 = a2;
		end else begin
			sel_d.d2 = box_s28.pbx - box_s28.pax;
			sel_d.n2 = box_s28.pby - box_s28.pay;
			sel_d.m2 = x2;
		end
		sel_d.pay  = box_s28.pay;
		sel_d.bly  = box_s28.bly;
		sel_d.tr_y = box_s28.tr_y;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s29 <= sel_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv1_s30.n   <= NW'(mag(sel_s29.n1));
			dv1_s30.m   <= MW'(mag(sel_s29.m1));
			dv1_s30.d   <= NW'(mag(sel_s29.d1));
			dv1_s30.neg <= sel_s29.n1[XW-1] ^ sel_s29.m1[XW-1] ^ sel_s29.d1[XW-1];
			dv2_s30.n   <= NW'(mag(sel_s29.n2));
			dv2_s30.m   <= MW'(mag(sel_s29.m2));
			dv2_s30.d   <= NW'(mag(sel_s29.d2));
			dv2_s30.neg <= sel_s29.n2[XW-1] ^ sel_s29.m2[XW-1] ^ sel_s29.d2[XW-1];
			side_s[0]   <= '{cond1: sel_s29.cond1, cond2: sel_s29.cond2,
				reject: sel_s29.reject, pay: sel_s29.pay, bly: sel_s29.bly,
				tr_y: sel_s29.tr_y};
		end
	end

	for (genvar j = 0; j < DIV_LAT; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[j+1] <= side_s[j];
			end
		end
	end

	rrc_div u_div1 (
		.clk (clk),
		.adv (adv),
		.din (dv1_s30),
		.quo (quo1)
	);

	rrc_div u_div2 (
		.clk (clk),
		.adv (adv),
		.din (dv2_s30),
		.quo (quo2)
	);

	assign e1 = side_s[DIV_LAT].cond1 ? quo1 + side_s[DIV_LAT].pay : side_s[DIV_LAT].pay;
	assign e2 = side_s[DIV_LAT].cond2 ? quo2 - side_s[DIV_LAT].pay : -side_s[DIV_LAT].pay;

	always_ff @(posedge clk) begin
		if (adv) begin
			ovl_s69 <= !side_s[DIV_LAT].reject
				&& !((e1 < side_s[DIV_LAT].bly && e2 < side_s[DIV_LAT].bly)
				|| (e1 > side_s[DIV_LAT].tr_y && e2 > side_s[DIV_LAT].tr_y));
		end
	end

endmodule

// ===== sv/rrc_checker.sv =====
// Port-level checker of the rotated rectangle collision block and its bind.
module rrc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic overlap
);

	// With no word waiting at the output the pipeline always takes a new pair.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while no result was pending");

	// A stalled result freezes the pipeline, so nothing may enter behind it.
	a_no_entry_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while the pipeline was stalled");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(overlap)))
		else $error("stalled result changed or vanished");

endmodule

bind rotated_rectangle_collision rrc_checker u_rrc_checker (.*);
